[src/hlcfp_pkg.sv]
// Package for the header/length/checksum frame parser.
// Holds the framing byte constants, the result kind codes and the result record type.
// Has no dependencies.
package hlcfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'hCC;
  localparam logic [7:0] TAIL_BYTE  = 8'hEE;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_FRAME_END = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  command;
    logic [15:0] frame_id;
    logic [15:0] frame_length;
    logic [7:0]  computed_sum;
    logic [7:0]  received_sum;
    logic        tail_ok;
  } result_t;

endpackage

[src/hlcfp_core.sv]
// Parser core: frame state, header fields, running sum and result formation.
// Depends on hlcfp_pkg for the framing constants and the result record type.
module hlcfp_core import hlcfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [3:0] ST_HDR1    = 4'd0;
  localparam logic [3:0] ST_HDR2    = 4'd1;
  localparam logic [3:0] ST_CMD     = 4'd2;
  localparam logic [3:0] ST_ID_HI   = 4'd3;
  localparam logic [3:0] ST_ID_LO   = 4'd4;
  localparam logic [3:0] ST_LEN_HI  = 4'd5;
  localparam logic [3:0] ST_LEN_LO  = 4'd6;
  localparam logic [3:0] ST_PAYLOAD = 4'd7;
  localparam logic [3:0] ST_CSUM    = 4'd8;
  localparam logic [3:0] ST_TAIL    = 4'd9;

  logic [3:0]  state_r, state_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  command_r, command_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  checksum_r, checksum_nxt;
  logic [15:0] count_inc;
  logic [7:0]  sum_base;

  always_comb begin
    state_nxt    = state_r;
    command_nxt  = command_r;
    id_nxt       = id_r;
    length_nxt   = length_r;
    count_nxt    = count_r;
    checksum_nxt = checksum_r;
    sum_base     = sum_r;
    count_inc    = count_r + 16'd1;
    res_valid    = 1'b0;
    res          = '0;
    res.command      = command_r;
    res.frame_id     = id_r;
    res.frame_length = length_r;
    case (state_r)
      ST_HDR1: begin
        if (rx_byte == HDR_FIRST) begin
          state_nxt = ST_HDR2;
          sum_base  = 8'd0;
        end
      end
      ST_HDR2: begin
        if (rx_byte == HDR_SECOND) begin
          state_nxt = ST_CMD;
        end
      end
      ST_CMD: begin
        command_nxt = rx_byte;
        state_nxt   = ST_ID_HI;
      end
      ST_ID_HI: begin
        id_nxt    = {rx_byte, 8'd0};
        state_nxt = ST_ID_LO;
      end
      ST_ID_LO: begin
        id_nxt    = {id_r[15:8], rx_byte};
        state_nxt = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        length_nxt = {rx_byte, 8'd0};
        state_nxt  = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        length_nxt = {length_r[15:8], rx_byte};
        count_nxt  = 16'd0;
        state_nxt  = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        res_valid         = 1'b1;
        res.result_kind   = KIND_PAYLOAD;
        res.payload_byte  = rx_byte;
        res.payload_index = count_r;
        res.computed_sum  = sum_r + rx_byte;
        count_nxt         = count_inc;
        if (count_inc >= length_r) begin
          state_nxt = ST_CSUM;
        end
      end
      ST_CSUM: begin
        checksum_nxt = rx_byte;
        state_nxt    = ST_TAIL;
      end
      ST_TAIL: begin
        res_valid        = 1'b1;
        res.result_kind  = KIND_FRAME_END;
        res.computed_sum = sum_r - checksum_r;
        res.received_sum = checksum_r;
        res.tail_ok      = (rx_byte == TAIL_BYTE);
        state_nxt        = ST_HDR1;
      end
      default: begin
        state_nxt = ST_HDR1;
      end
    endcase
    sum_nxt = sum_base + rx_byte;
    res_valid = res_valid & in_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HDR1;
      sum_r      <= 8'd0;
      command_r  <= 8'd0;
      id_r       <= 16'd0;
      length_r   <= 16'd0;
      count_r    <= 16'd0;
      checksum_r <= 8'd0;
    end else if (in_fire) begin
      state_r    <= state_nxt;
      sum_r      <= sum_nxt;
      command_r  <= command_nxt;
      id_r       <= id_nxt;
      length_r   <= length_nxt;
      count_r    <= count_nxt;
      checksum_r <= checksum_nxt;
    end
  end

endmodule

[src/hlcfp_out_buf.sv]
// Two-entry result buffer between the parser core and the result channel.
// Depends on hlcfp_pkg for the result record type.
module hlcfp_out_buf import hlcfp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = ent_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/header_length_checksum_frame_parser.sv]
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_rx_byte
// out_      output     out_valid / out_ready  result kind, payload byte and index, frame fields
//
// One byte per cycle is taken unless stalled; the parser state updates on each transaction.
// A payload or frame-end result is registered into the result buffer and leaves it in order.
// A two-entry result buffer lets the input run while a result waits to be taken.
// Input stalls only when both buffer entries are occupied. Reset is synchronous, active low.
// Top level of the frame parser; depends on hlcfp_pkg, hlcfp_core and hlcfp_out_buf.
module header_length_checksum_frame_parser import hlcfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_command,
  output logic [15:0] out_frame_id,
  output logic [15:0] out_frame_length,
  output logic [7:0]  out_computed_sum,
  output logic [7:0]  out_received_sum,
  output logic        out_tail_ok
);

  logic    in_fire;
  logic    buf_full;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign in_ready = ~buf_full;
  assign in_fire  = in_valid & in_ready;

  hlcfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  hlcfp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_result_kind   = out_data.result_kind;
  assign out_payload_byte  = out_data.payload_byte;
  assign out_payload_index = out_data.payload_index;
  assign out_command       = out_data.command;
  assign out_frame_id      = out_data.frame_id;
  assign out_frame_length  = out_data.frame_length;
  assign out_computed_sum  = out_data.computed_sum;
  assign out_received_sum  = out_data.received_sum;
  assign out_tail_ok       = out_data.tail_ok;

endmodule
